[rtl/wcms_pkg.sv]
// ----------------------------------------------------------------------------
// wcms_pkg
// Shared constants for the weighted constraint move scorer.
// ----------------------------------------------------------------------------
package wcms_pkg;
    localparam int CON_DEPTH    = 1024;
    localparam int VALUE_WIDTH  = 32;
    localparam int WEIGHT_WIDTH = 24;

    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_SCORE  = 2'd1;
    localparam logic [1:0] KIND_BUMP   = 2'd2;
    localparam logic [1:0] KIND_SMOOTH = 2'd3;

    localparam logic [1:0] DONE_SCORE  = 2'd0;
    localparam logic [1:0] DONE_BUMP   = 2'd1;
    localparam logic [1:0] DONE_SMOOTH = 2'd2;

    localparam logic [2:0] REG_FEASIBLE  = 3'd0;
    localparam logic [2:0] REG_TOLERANCE = 3'd1;
    localparam logic [2:0] REG_WCAP      = 3'd2;
    localparam logic [2:0] REG_OBJCAP    = 3'd3;
    localparam logic [2:0] REG_COUNT     = 3'd4;
endpackage

[rtl/wcms_ram.sv]
// ----------------------------------------------------------------------------
// wcms_ram
// Generic single-port RAM, registered read.
// ----------------------------------------------------------------------------
module wcms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end
endmodule

[rtl/weighted_constraint_move_scorer.sv]
// ----------------------------------------------------------------------------
// weighted_constraint_move_scorer
// Constraint table with weighted move scoring and weight bump/smooth walks.
// ----------------------------------------------------------------------------
// One item at a time; busy is high while an item is at work. A write goes
// to the table at the accept and leaves busy low. A score term runs table
// read, registered multiply, new left side, satisfaction test and accumulate;
// the result strobe comes on the last term. Bump and smooth walk the table
// through the single RAM port, reading each entry and then writing it back,
// over min(con_count,CON_DEPTH) entries; busy stays high until the strobe.
// o_done is high for exactly one cycle per result and the receiver cannot
// hold it off. Unwritten entries read as undefined.
module weighted_constraint_move_scorer #(
    parameter int CON_DEPTH    = wcms_pkg::CON_DEPTH,
    parameter int VALUE_WIDTH  = wcms_pkg::VALUE_WIDTH,
    parameter int WEIGHT_WIDTH = wcms_pkg::WEIGHT_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_cfg_we,
    input  logic [2:0]                     i_cfg_index,
    input  logic [23:0]                    i_cfg_data,
    input  logic [1:0]                     i_kind,
    input  logic [9:0]                     i_con_index,
    input  logic signed [31:0]             i_lhs,
    input  logic signed [31:0]             i_rhs,
    input  logic [23:0]                    i_weight,
    input  logic signed [31:0]             i_coeff,
    input  logic signed [31:0]             i_delta,
    input  logic                           i_last,
    output logic                           o_done,
    output logic [1:0]                     o_done_kind,
    output logic signed [31:0]             o_score
);
    localparam int AW = $clog2(CON_DEPTH);
    localparam int VW = VALUE_WIDTH;
    localparam int WW = WEIGHT_WIDTH;
    localparam int MW = 2 * VW + WW;
    localparam int CW = AW + 1;
    localparam logic signed [VW+1:0] VMAX = (VW+2)'((64'sd1 <<< (VW-1)) - 1);
    localparam logic signed [VW+1:0] VMIN = -VMAX - 1;
    localparam logic [WW-1:0] WMAX = {WW{1'b1}};

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SRD  = 3'd1;  // score: read data arrives
    localparam logic [2:0] ST_SMUL = 3'd2;  // product registered
    localparam logic [2:0] ST_SACC = 3'd3;  // accumulate
    localparam logic [2:0] ST_WRD  = 3'd4;  // walk: read issued
    localparam logic [2:0] ST_WWR  = 3'd5;  // walk: write back
    localparam logic [2:0] ST_DONE = 3'd6;

    // configuration
    logic          r_feas;
    logic [15:0]   r_tol;
    logic [23:0]   r_wcap, r_ocap;
    logic [10:0]   r_count;

    logic [2:0]    r_state;
    logic [1:0]    r_kind;
    logic [AW-1:0] r_idx;
    logic          r_last;
    logic signed [31:0] r_coeff, r_delta;
    logic signed [63:0] r_prod;
    logic signed [VW+1:0] r_new;
    logic signed [31:0] r_acc;
    logic [CW-1:0] r_walk, r_len;
    logic          r_done;
    logic [1:0]    r_done_kind;
    logic signed [31:0] r_score;

    // memory port
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [MW-1:0] ram_wdata, ram_rdata;

    wcms_ram #(.WIDTH(MW), .DEPTH(CON_DEPTH)) u_tab (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    logic signed [VW-1:0] rd_lhs, rd_rhs;
    logic [WW-1:0]        rd_w;
    assign rd_lhs = ram_rdata[MW-1 -: VW];
    assign rd_rhs = ram_rdata[WW +: VW];
    assign rd_w   = ram_rdata[WW-1:0];

    function automatic logic signed [VW-1:0] sat_in(input logic signed [31:0] v);
        logic signed [VW+32:0] e;
        e = (VW+33)'(v);
        if (e > (VW+33)'(VMAX)) return VMAX[VW-1:0];
        if (e < (VW+33)'(VMIN)) return VMIN[VW-1:0];
        return e[VW-1:0];
    endfunction

    // satisfaction with tolerance, wide enough for no overflow
    logic signed [VW+1:0] rhs_tol;
    logic                 pre_sat, now_sat, obj_lt;
    assign rhs_tol = (VW+2)'(rd_rhs) + (VW+2)'($signed({1'b0, r_tol}));
    assign pre_sat = (VW+2)'(rd_lhs) < rhs_tol;
    assign now_sat = r_new < rhs_tol;
    assign obj_lt  = r_new < (VW+2)'(rd_rhs);

    // new left side: floor(prod/65536) is an arithmetic shift
    logic signed [63:0]   shf;
    logic signed [VW+48:0] sum_w;
    assign shf   = r_prod >>> 16;
    assign sum_w = (VW+49)'(rd_lhs) + (VW+49)'(shf);

    logic signed [WW+1:0] term;
    logic signed [33:0]   acc_sum;
    always_comb begin
        term = '0;
        if (r_idx == '0) begin
            if (r_feas) term = obj_lt ? (WW+2)'(rd_w) : -(WW+2)'(rd_w);
        end else if (!pre_sat && now_sat) begin
            term = (WW+2)'(rd_w);
        end else if (pre_sat && !now_sat) begin
            term = -(WW+2)'(rd_w);
        end else if (!pre_sat && !now_sat) begin
            term = ((VW+2)'(rd_lhs) > r_new) ? (WW+2)'(rd_w >> 2)
                                             : -(WW+2)'(rd_w >> 2);
        end
        acc_sum = 34'(r_acc) + 34'(term);
    end

    // walk weight update
    logic [WW-1:0] w_new;
    always_comb begin
        w_new = rd_w;
        if (r_kind == wcms_pkg::KIND_BUMP) begin
            if (r_idx == '0) begin
                if (r_feas && !pre_sat && 32'(rd_w) <= 32'(r_ocap) && rd_w < WMAX)
                    w_new = rd_w + 1'b1;
            end else if (!pre_sat && 32'(rd_w) < 32'(r_wcap) && rd_w < WMAX) begin
                w_new = rd_w + 1'b1;
            end
        end else if (pre_sat && rd_w != '0) begin
            w_new = rd_w - 1'b1;
        end
    end

    // bump visits 1..n-1 then entry 0; smooth visits 0..n-1
    logic [CW-1:0] walk_addr;
    assign walk_addr = (r_kind == wcms_pkg::KIND_BUMP && r_walk == r_len - 1'b1)
                       ? '0
                       : ((r_kind == wcms_pkg::KIND_BUMP) ? r_walk + 1'b1 : r_walk);

    logic accept;
    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_idx;
        ram_wdata = {rd_lhs, rd_rhs, w_new};
        if (accept) begin
            ram_addr = AW'(i_con_index);
            if (i_kind == wcms_pkg::KIND_WRITE) begin
                ram_we    = 1'b1;
                ram_wdata = {sat_in(i_lhs), sat_in(i_rhs), WW'(i_weight)};
            end
        end else if (r_state == ST_WRD) begin
            ram_addr = walk_addr[AW-1:0];
        end else if (r_state == ST_WWR) begin
            ram_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feas  <= 1'b0;
            r_tol   <= '0;
            r_wcap  <= 24'hFFFFFF;
            r_ocap  <= 24'hFFFFFF;
            r_count <= 11'd1024;
            r_state <= ST_IDLE;
            r_acc   <= '0;
            r_done  <= 1'b0;
            r_walk  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    wcms_pkg::REG_FEASIBLE:  r_feas  <= i_cfg_data[0];
                    wcms_pkg::REG_TOLERANCE: r_tol   <= i_cfg_data[15:0];
                    wcms_pkg::REG_WCAP:      r_wcap  <= i_cfg_data;
                    wcms_pkg::REG_OBJCAP:    r_ocap  <= i_cfg_data;
                    wcms_pkg::REG_COUNT:     r_count <= i_cfg_data[10:0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_kind  <= i_kind;
                        r_idx   <= AW'(i_con_index);
                        r_last  <= i_last;
                        r_coeff <= i_coeff;
                        r_delta <= i_delta;
                        r_walk  <= '0;
                        r_len   <= (32'(r_count) < CON_DEPTH) ? CW'(r_count)
                                                               : CW'(CON_DEPTH);
                        case (i_kind)
                            wcms_pkg::KIND_WRITE: r_state <= ST_IDLE;
                            wcms_pkg::KIND_SCORE: r_state <= ST_SRD;
                            default:              r_state <= ST_WRD;
                        endcase
                    end
                end
                ST_SRD: begin
                    r_prod  <= r_coeff * r_delta;
                    r_state <= ST_SMUL;
                end
                ST_SMUL: begin
                    if (sum_w > (VW+49)'(VMAX))      r_new <= VMAX;
                    else if (sum_w < (VW+49)'(VMIN)) r_new <= VMIN;
                    else                             r_new <= sum_w[VW+1:0];
                    r_state <= ST_SACC;
                end
                ST_SACC: begin
                    logic signed [31:0] a;
                    a = (acc_sum > 34'sd2147483647) ? 32'sh7FFFFFFF :
                        (acc_sum < -34'sd2147483648) ? 32'sh80000000 : acc_sum[31:0];
                    if (r_last) begin
                        r_acc       <= '0;
                        r_done      <= 1'b1;
                        r_done_kind <= wcms_pkg::DONE_SCORE;
                        r_score     <= a;
                    end else begin
                        r_acc <= a;
                    end
                    r_state <= ST_IDLE;
                end
                ST_WRD: begin
                    if (r_walk >= r_len || (r_kind == wcms_pkg::KIND_BUMP && r_len == '0)) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_idx   <= walk_addr[AW-1:0];
                        r_state <= ST_WWR;
                    end
                end
                ST_WWR: begin
                    r_walk  <= r_walk + 1'b1;
                    r_state <= ST_WRD;
                end
                ST_DONE: begin
                    r_done      <= 1'b1;
                    r_done_kind <= (r_kind == wcms_pkg::KIND_BUMP) ? wcms_pkg::DONE_BUMP
                                                                 : wcms_pkg::DONE_SMOOTH;
                    r_score     <= '0;
                    r_state     <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done      = r_done;
    assign o_done_kind = r_done_kind;
    assign o_score     = r_score;
endmodule
